### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks of the sparse row matrix builder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define SRMB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sparse row matrix builder check failed");

// Next-cycle implication, off while reset is high
`define SRMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sparse row matrix builder check failed");

`endif

### src/srmb_pkg.sv
// ---------------------------------------------------------------------------
// Sparse row matrix builder package
// Field widths, operation and status codes, sequencer states and the
// structs shared by the builder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srmb_pkg;

   localparam int KIND_BITS      = 2;
   localparam int ROW_BITS       = 10;
   localparam int COL_BITS       = 10;
   localparam int DATA_BITS      = 32;
   localparam int STATUS_BITS    = 3;
   localparam int POS_BITS       = 13;
   localparam int NZ_BITS        = 14;
   localparam int ROW_COUNT_BITS = 11;
   localparam int CSR_DATA_BITS  = 11;

   // operation codes
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_SET   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_SUM   = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd3;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_UPDATED     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_INSERTED    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_READ_FOUND  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_READ_ABSENT = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_ROW_ORDER   = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_STORE_FULL  = 3'd5;

   // register indexes
   localparam logic CSR_ROW_COUNT    = 1'b0;
   localparam logic CSR_INDEX_ORIGIN = 1'b1;

   localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RESET = 11'd1024;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_PTR_LO,
      S_PTR_HI,
      S_SCAN,
      S_HIT,
      S_MISS,
      S_LINK,
      S_DONE
   } srmb_state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]        kind;
      logic [ROW_BITS-1:0]         row;
      logic [COL_BITS-1:0]         column;
      logic signed [DATA_BITS-1:0] value;
   } srmb_req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] read_value;
      logic [STATUS_BITS-1:0]      status;
      logic [POS_BITS-1:0]         position;
      logic [NZ_BITS-1:0]          nonzeros;
   } srmb_rsp_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic is_clear;
      logic is_read;
      logic row_begun;
      logic scan_hit;
      logic scan_end;
      logic insert_ok;
      logic out_free;
   } srmb_flag_type;

   // sequencer step strobes
   typedef struct packed {
      logic ready;
      logic check;
      logic ptr_lo;
      logic ptr_hi;
      logic scan;
      logic hit;
      logic miss;
      logic link;
      logic done;
   } srmb_ctrl_type;

endpackage

### src/srmb_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srmb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/srmb_ctrl.sv
// ---------------------------------------------------------------------------
// Sparse row matrix builder sequencer
// Steps one access through pointer fetch, row scan, update or append (or a clear)
// and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srmb_ctrl import srmb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  srmb_flag_type flags,
   output srmb_ctrl_type ctl
);

   srmb_state_type state_ff;
   srmb_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (flags.req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (flags.is_clear) begin
               state_in = S_DONE;
            end else if (flags.row_begun) begin
               state_in = S_PTR_LO;
            end else begin
               state_in = S_MISS;
            end
         end
         S_PTR_LO: begin
            state_in = S_PTR_HI;
         end
         S_PTR_HI: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (flags.scan_hit) begin
               state_in = S_HIT;
            end else if (flags.scan_end) begin
               state_in = S_MISS;
            end
         end
         S_HIT: begin
            state_in = S_DONE;
         end
         S_MISS: begin
            if (!flags.is_read && flags.insert_ok) begin
               state_in = S_LINK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LINK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (flags.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         S_IDLE:   ctl.ready  = 1'b1;
         S_CHECK:  ctl.check  = 1'b1;
         S_PTR_LO: ctl.ptr_lo = 1'b1;
         S_PTR_HI: ctl.ptr_hi = 1'b1;
         S_SCAN:   ctl.scan   = 1'b1;
         S_HIT:    ctl.hit    = 1'b1;
         S_MISS:   ctl.miss   = 1'b1;
         S_LINK:   ctl.link   = 1'b1;
         S_DONE:   ctl.done   = 1'b1;
         default:  ctl        = '0;
      endcase
   end

endmodule

### src/sparse_row_matrix_builder_unit.sv
// ---------------------------------------------------------------------------
// Sparse row matrix builder
// Builds a compressed sparse row matrix one access at a time: clear, set,
// saturating sum and read, with in-order row append.
// ---------------------------------------------------------------------------
//   channel   ports                          direction  transfer when
//   request   req_valid/req_stall/req_payload in        req_valid & !req_stall
//   result    rsp_valid/rsp_stall/rsp_payload out       rsp_valid & !rsp_stall
//   config    csr_we/csr_index/csr_wdata      in        csr_we
//
// An access on a begun row walks its entries in the serial column scan, one
// store entry per cycle through a single compare; an access that appends also
// passes the link step. A clear skips the scan; an unbegun row goes straight
// to the miss step. One access is in flight at a time; a finished result
// sits in the output register so the next request is taken while it waits.
// Reset is synchronous; the pointer, column and value stores are not
// initialised and hold nothing meaningful until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sparse_row_matrix_builder_unit import srmb_pkg::*; #(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_ENTRIES = 8192,
   parameter int VALUE_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  srmb_req_type             req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output srmb_rsp_type             rsp_payload,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int RAW = $clog2(MAX_ROWS + 1);
   localparam int AW  = $clog2(MAX_ENTRIES);
   localparam int EW  = $clog2(MAX_ENTRIES + 1);
   localparam int PW  = $clog2(MAX_ENTRIES + 2);
   localparam int VW  = VALUE_BITS;
   localparam int XW  = (VW > DATA_BITS) ? VW : DATA_BITS;
   localparam int CW  = ((RAW > ROW_COUNT_BITS) ? RAW : ROW_COUNT_BITS) + 1;

   localparam logic [CW-1:0] MAX_ROWS_X    = CW'(MAX_ROWS);
   localparam logic [EW-1:0] MAX_ENTRIES_X = EW'(MAX_ENTRIES);
   localparam logic [VW-1:0] VAL_MAX       = {1'b0, {(VW - 1){1'b1}}};
   localparam logic [VW-1:0] VAL_MIN       = {1'b1, {(VW - 1){1'b0}}};

   srmb_flag_type flags;
   srmb_ctrl_type ctl;

   // control state
   logic [ROW_COUNT_BITS-1:0] row_count_ff, row_count_in;
   logic                      origin_ff, origin_in;
   logic [RAW-1:0]            rows_begun_ff, rows_begun_in;
   logic [EW-1:0]             ec_ff, ec_in;
   logic                      pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // item and scan registers
   logic [KIND_BITS-1:0]        kind_ff, kind_in;
   logic [ROW_BITS-1:0]         row_ff, row_in;
   logic [COL_BITS-1:0]         col_ff, col_in;
   logic signed [VW-1:0]        val_ff, val_in;
   logic [EW-1:0]               lo_ff, lo_in;
   logic [EW-1:0]               hi_ff, hi_in;
   logic [EW-1:0]               p_ff, p_in;
   logic [EW-1:0]               ppos_ff, ppos_in;
   logic [EW-1:0]               pos_ff, pos_in;
   logic signed [VW-1:0]        cur_ff, cur_in;
   logic signed [DATA_BITS-1:0] res_rd_ff, res_rd_in;
   logic [STATUS_BITS-1:0]      res_status_ff, res_status_in;
   logic [EW-1:0]               res_pos_ff, res_pos_in;
   srmb_rsp_type                rsp_payload_ff, rsp_payload_in;

   // store ports
   logic           rs_we;
   logic [RAW-1:0] rs_waddr, rs_raddr;
   logic [PW-1:0]  rs_wdata, rs_rdata;
   logic           col_we, val_we;
   logic [AW-1:0]  st_waddr, st_raddr;
   logic [COL_BITS-1:0] col_rdata, col_wdata;
   logic [VW-1:0]  val_wdata, val_rdata;

   // datapath terms
   logic signed [VW-1:0] val_clamped;
   logic signed [VW:0]   sum_x;
   logic [VW-1:0]        sat_val;
   logic signed [XW-1:0] cur_x;
   logic signed [PW:0]   ptr_diff, ec_x, lo_x;
   logic [EW-1:0]        lo_calc, hi_calc;
   logic [CW-1:0]        row_x, row_p1_x, rb_x, rc_x;
   logic [RAW-1:0]       row_addr, row_next_addr;
   logic [COL_BITS-1:0]  col_norm;
   logic                 is_last, is_next, row_full, store_full, out_free;
   logic [PW-1:0]        ptr_from_ec;

   srmb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   srmb_ram #(.WIDTH(PW), .DEPTH(MAX_ROWS + 1)) u_row_start (
      .clock (clock),
      .we    (rs_we),
      .waddr (rs_waddr),
      .wdata (rs_wdata),
      .raddr (rs_raddr),
      .rdata (rs_rdata)
   );

   srmb_ram #(.WIDTH(COL_BITS), .DEPTH(MAX_ENTRIES)) u_columns (
      .clock (clock),
      .we    (col_we),
      .waddr (st_waddr),
      .wdata (col_wdata),
      .raddr (st_raddr),
      .rdata (col_rdata)
   );

   srmb_ram #(.WIDTH(VW), .DEPTH(MAX_ENTRIES)) u_values (
      .clock (clock),
      .we    (val_we),
      .waddr (st_waddr),
      .wdata (val_wdata),
      .raddr (st_raddr),
      .rdata (val_rdata)
   );

   // clamp the incoming value to the stored range
   generate
      if (VW >= DATA_BITS) begin : g_wide_val
         assign val_clamped = VW'($signed(req_payload.value));
      end else begin : g_narrow_val
         localparam logic signed [DATA_BITS-1:0] VMAX32 =
            DATA_BITS'((64'sd1 <<< (VW - 1)) - 64'sd1);
         localparam logic signed [DATA_BITS-1:0] VMIN32 = -VMAX32 - 32'sd1;
         always_comb begin
            if ($signed(req_payload.value) > VMAX32) begin
               val_clamped = VMAX32[VW-1:0];
            end else if ($signed(req_payload.value) < VMIN32) begin
               val_clamped = VMIN32[VW-1:0];
            end else begin
               val_clamped = req_payload.value[VW-1:0];
            end
         end
      end
   endgenerate

   // saturating adder
   assign sum_x   = (VW + 1)'(cur_ff) + (VW + 1)'(val_ff);
   assign sat_val = (sum_x[VW] != sum_x[VW-1]) ? (sum_x[VW] ? VAL_MIN : VAL_MAX)
                                               : sum_x[VW-1:0];
   assign cur_x   = XW'(cur_ff);

   // row pointer less origin, clamped to the stored entries
   assign ptr_diff = $signed({1'b0, rs_rdata}) - $signed({{PW{1'b0}}, origin_ff});
   assign ec_x     = $signed((PW + 1)'(ec_ff));
   assign lo_x     = $signed((PW + 1)'(lo_ff));

   always_comb begin
      if (ptr_diff < 0) begin
         lo_calc = '0;
      end else if (ptr_diff > ec_x) begin
         lo_calc = ec_ff;
      end else begin
         lo_calc = ptr_diff[EW-1:0];
      end
      if (ptr_diff < lo_x) begin
         hi_calc = lo_ff;
      end else if (ptr_diff > ec_x) begin
         hi_calc = ec_ff;
      end else begin
         hi_calc = ptr_diff[EW-1:0];
      end
   end

   assign row_x         = CW'(row_ff);
   assign row_p1_x      = row_x + 1'b1;
   assign rb_x          = CW'(rows_begun_ff);
   assign rc_x          = CW'(row_count_ff);
   assign row_addr      = row_x[RAW-1:0];
   assign row_next_addr = row_p1_x[RAW-1:0];
   assign is_last       = (rb_x != '0) && (row_x == rb_x - 1'b1);
   assign is_next       = (row_x == rb_x);
   assign row_full      = (rb_x >= rc_x) || (rb_x >= MAX_ROWS_X);
   assign store_full    = (ec_ff >= MAX_ENTRIES_X);
   assign col_norm      = col_rdata - COL_BITS'(origin_ff);
   assign ptr_from_ec   = PW'(ec_ff) + PW'(origin_ff);
   assign col_wdata     = col_ff + COL_BITS'(origin_ff);
   assign st_raddr      = p_ff[AW-1:0];
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      flags.req_valid = req_valid;
      flags.is_clear  = (kind_ff == KIND_CLEAR);
      flags.is_read   = (kind_ff == KIND_READ);
      flags.row_begun = (row_x < rb_x) && (row_x < MAX_ROWS_X);
      flags.scan_hit  = pend_ff && (col_norm == col_ff);
      flags.scan_end  = (p_ff >= hi_ff);
      flags.insert_ok = (is_last || is_next) && !(is_next && row_full) && !store_full;
      flags.out_free  = out_free;
   end

   always_comb begin
      row_count_in   = row_count_ff;
      origin_in      = origin_ff;
      rows_begun_in  = rows_begun_ff;
      ec_in          = ec_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff;
      kind_in        = kind_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      val_in         = val_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      p_in           = p_ff;
      ppos_in        = ppos_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      res_rd_in      = res_rd_ff;
      res_status_in  = res_status_ff;
      res_pos_in     = res_pos_ff;
      rsp_payload_in = rsp_payload_ff;
      rs_we          = 1'b0;
      rs_waddr       = row_addr;
      rs_wdata       = ptr_from_ec;
      rs_raddr       = ctl.ptr_lo ? row_next_addr : row_addr;
      col_we         = 1'b0;
      val_we         = 1'b0;
      st_waddr       = ec_ff[AW-1:0];
      val_wdata      = val_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ROW_COUNT:    row_count_in = csr_wdata[ROW_COUNT_BITS-1:0];
            CSR_INDEX_ORIGIN: origin_in    = csr_wdata[0];
            default:          row_count_in = row_count_ff;
         endcase
      end

      if (ctl.ready && req_valid) begin
         kind_in = req_payload.kind;
         row_in  = req_payload.row;
         col_in  = req_payload.column;
         val_in  = val_clamped;
      end

      if (ctl.check && (kind_ff == KIND_CLEAR)) begin
         rows_begun_in = '0;
         ec_in         = '0;
         rs_we         = 1'b1;
         rs_waddr      = '0;
         rs_wdata      = PW'(origin_ff);
         res_status_in = ST_UPDATED;
         res_pos_in    = '0;
         res_rd_in     = '0;
      end

      if (ctl.ptr_lo) begin
         lo_in = lo_calc;
      end

      if (ctl.ptr_hi) begin
         hi_in   = hi_calc;
         p_in    = lo_ff;
         pend_in = 1'b0;
      end

      // one read issued and one column compared per cycle
      if (ctl.scan) begin
         if (p_ff < hi_ff) begin
            p_in    = p_ff + 1'b1;
            pend_in = 1'b1;
            ppos_in = p_ff;
         end else begin
            pend_in = 1'b0;
         end
         if (flags.scan_hit) begin
            pos_in = ppos_ff;
            cur_in = $signed(val_rdata);
         end
      end

      if (ctl.hit) begin
         res_pos_in = pos_ff;
         res_rd_in  = '0;
         st_waddr   = pos_ff[AW-1:0];
         case (kind_ff)
            KIND_READ: begin
               res_status_in = ST_READ_FOUND;
               res_rd_in     = cur_x[DATA_BITS-1:0];
            end
            KIND_SET: begin
               val_we        = 1'b1;
               val_wdata     = val_ff;
               res_status_in = ST_UPDATED;
            end
            KIND_SUM: begin
               val_we        = 1'b1;
               val_wdata     = sat_val;
               res_status_in = ST_UPDATED;
            end
            default: begin
               res_status_in = ST_UPDATED;
            end
         endcase
      end

      if (ctl.miss) begin
         res_pos_in = '0;
         res_rd_in  = '0;
         if (kind_ff == KIND_READ) begin
            res_status_in = ST_READ_ABSENT;
         end else if (!is_last && !is_next) begin
            res_status_in = ST_ROW_ORDER;
         end else if (is_next && row_full) begin
            res_status_in = ST_ROW_ORDER;
         end else if (store_full) begin
            res_status_in = ST_STORE_FULL;
         end else begin
            // append at the end of the store; open the row if it is new
            col_we    = 1'b1;
            val_we    = 1'b1;
            val_wdata = val_ff;
            st_waddr  = ec_ff[AW-1:0];
            if (is_next) begin
               rs_we         = 1'b1;
               rs_waddr      = row_addr;
               rows_begun_in = rows_begun_ff + 1'b1;
            end
            ec_in         = ec_ff + 1'b1;
            res_pos_in    = ec_ff;
            res_status_in = ST_INSERTED;
         end
      end

      // close the row: its end pointer follows the new entry count
      if (ctl.link) begin
         rs_we    = 1'b1;
         rs_waddr = row_next_addr;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.done && out_free) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.read_value = res_rd_ff;
         rsp_payload_in.status     = res_status_ff;
         rsp_payload_in.position   = POS_BITS'(res_pos_ff);
         rsp_payload_in.nonzeros   = NZ_BITS'(ec_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= ROW_COUNT_RESET;
         origin_ff     <= 1'b0;
         rows_begun_ff <= '0;
         ec_ff         <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_count_ff  <= row_count_in;
         origin_ff     <= origin_in;
         rows_begun_ff <= rows_begun_in;
         ec_ff         <= ec_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      val_ff         <= val_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      p_ff           <= p_in;
      ppos_ff        <= ppos_in;
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      res_rd_ff      <= res_rd_in;
      res_status_ff  <= res_status_in;
      res_pos_ff     <= res_pos_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // hold off requests while reset is high
   assign req_stall   = !ctl.ready || reset;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `SRMB_ASSERT_IMPLY(a_count_bounds, clock, reset, 1'b1, (rows_begun_ff <= MAX_ROWS) && (ec_ff <= MAX_ENTRIES))
   `SRMB_ASSERT_NEXT(a_count_step, clock, reset, !(ctl.check && (kind_ff == KIND_CLEAR)), (ec_ff == $past(ec_ff)) || (ec_ff == $past(ec_ff) + 1'b1))
   `SRMB_ASSERT_IMPLY(a_scan_window, clock, reset, ctl.scan, (lo_ff <= p_ff) && (p_ff <= hi_ff) && (hi_ff <= ec_ff))

endmodule
